// ----- design/msba_pkg.sv -----
// msba_pkg: shared widths, size codes, queue word and back-end state type
// for the Marsden square bin allocator. No dependencies.
`default_nettype none

package msba_pkg;

    localparam int MAJOR_W = 14;
    localparam int SUB_W   = 7;
    localparam int LAT_W   = 18;
    localparam int LON_W   = 19;
    localparam int BIN_W   = 6;
    localparam int COUNT_W = 32;

    // square_size codes
    localparam logic [1:0] SIZE_10DEG  = 2'd0;
    localparam logic [1:0] SIZE_5DEG   = 2'd1;
    localparam logic [1:0] SIZE_2P5DEG = 2'd2;
    localparam logic [1:0] SIZE_1DEG   = 2'd3;

    // classified word handed from front to back
    typedef struct packed {
        logic [MAJOR_W-1:0] major;
        logic [SUB_W-1:0]   sub_key;
        logic               coarse;   // 10 deg: compare major only
    } msba_work_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD,
        B_CMP,
        B_MISS,
        B_CNT_RD,
        B_CNT_WR
    } msba_bstate_t;

endpackage

`default_nettype wire

// ----- design/marsden_square_bin_allocator.sv -----
// Marsden square bin allocator: top level with the square_size register,
// classifier, queue and bin engine. Depends on msba_pkg.
// Path: classifier stages A and B, then the queue, then the engine.
// Engine steps per word: key read and compare per allocated bin until a hit, an allocation on a miss,
// then a count read-modify-write; one word at a time, and the scan sets throughput.
// Reset: rst_n async, active low; clears bins in use, count valid bits, queue, pipeline.
`default_nettype none

module marsden_square_bin_allocator
    import msba_pkg::*;
#(
    parameter int BIN_SLOTS = 50
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              square_size,
    // station words in
    input  logic                    push,
    output logic                    full,
    input  logic [MAJOR_W-1:0]      square_major,
    input  logic [SUB_W-1:0]        sub_square_one,
    input  logic signed [LAT_W-1:0] lat_millideg,
    input  logic signed [LON_W-1:0] lon_millideg,
    // bin words out
    output logic                    empty,
    input  logic                    pop,
    output logic [BIN_W-1:0]        bin_index,
    output logic                    new_bin,
    output logic [SUB_W-1:0]        sub_key,
    output logic [COUNT_W-1:0]      station_count
);

    logic [1:0] size_reg;

    logic       f_wr_valid;
    msba_work_t f_wr_word;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    msba_work_t q_word;

    // user must write the register only while idle, unchecked by the block; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_10DEG;
        else if (cfg_valid && cfg_ready)
            size_reg <= square_size;
    end

    // front: sub-key for the size in force when the word is accepted
    msba_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .square_major   (square_major),
        .sub_square_one (sub_square_one),
        .lat_millideg   (lat_millideg),
        .lon_millideg   (lon_millideg),
        .size           (size_reg),
        .wr_valid       (f_wr_valid),
        .wr_word        (f_wr_word),
        .wr_full        (q_full)
    );

    // decouples classifier from the multi-cycle bin scan
    msba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_wr_valid),
        .wr_word  (f_wr_word),
        .wr_full  (q_full),
        .rd_pop   (q_pop),
        .rd_empty (q_empty),
        .rd_word  (q_word)
    );

    // back: match, allocate, count; result register decouples the output
    msba_back #(
        .BIN_SLOTS (BIN_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_word        (q_word),
        .empty         (empty),
        .pop           (pop),
        .bin_index     (bin_index),
        .new_bin       (new_bin),
        .sub_key       (sub_key),
        .station_count (station_count)
    );

endmodule

`default_nettype wire

// ----- design/msba_front.sv -----
// msba_front: two-stage classifier that turns a station word into a
// (major, sub-key) queue word. Depends on msba_pkg.
`default_nettype none

module msba_front
    import msba_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [MAJOR_W-1:0]      square_major,
    input  logic [SUB_W-1:0]        sub_square_one,
    input  logic signed [LAT_W-1:0] lat_millideg,
    input  logic signed [LON_W-1:0] lon_millideg,
    input  logic [1:0]              size,
    output logic                    wr_valid,
    output msba_work_t              wr_word,
    input  logic                    wr_full
);

    localparam int MAG_W  = 19;          // magnitude of either coordinate
    localparam int PROD_W = 2 * MAG_W;
    localparam int T_W    = 12;          // tenths of a degree, < 4096
    localparam int P2_W   = 25;
    localparam int Q2_W   = 6;
    localparam int RECIP1_SHIFT = 25;    // x/100 = x*335545 >> 25
    localparam logic [MAG_W-1:0] RECIP1 = 19'd335545;
    localparam int RECIP2_SHIFT = 19;    // x/100 = x*5243 >> 19
    localparam logic [P2_W-1:0] RECIP2 = 25'd5243;
    localparam logic [MAG_W-1:0] HUNDRED_M = 19'd100;
    localparam logic [T_W-1:0]   HUNDRED_T = 12'd100;

    logic advance;

    // stage A
    logic                    a_valid_reg;
    logic [PROD_W-1:0]       a_prod_reg [2];
    logic [MAG_W-1:0]        a_mag_reg  [2];
    logic [1:0]              a_neg_reg;
    logic [MAJOR_W-1:0]      a_major_reg;
    logic [SUB_W-1:0]        a_ms1_reg;
    logic [1:0]              a_size_reg;

    // stage B
    logic                    b_valid_reg;
    logic [T_W-1:0]          b_t_reg  [2];
    logic [P2_W-1:0]         b_p2_reg [2];
    logic [MAJOR_W-1:0]      b_major_reg;
    logic [SUB_W-1:0]        b_ms1_reg;
    logic [1:0]              b_size_reg;

    logic [MAG_W-1:0]  coord_ext [2];
    logic [MAG_W-1:0]  mag       [2];
    logic [1:0]        neg;
    logic [PROD_W-1:0] prod      [2];
    logic [T_W-1:0]    t_raw     [2];
    logic [MAG_W-1:0]  rem       [2];
    logic [T_W-1:0]    t_adj     [2];
    logic [P2_W-1:0]   p2        [2];
    logic [Q2_W-1:0]   q2        [2];
    logic [T_W-1:0]    r_full    [2];
    logic [1:0]        quarter   [2];
    logic [14:0]       tens_prod;
    logic [3:0]        tens;
    logic [SUB_W-1:0]  units;
    logic [SUB_W-1:0]  key;

    assign advance  = !b_valid_reg || !wr_full;
    assign full     = !advance;
    assign wr_valid = b_valid_reg;

    // stage A: magnitude and first reciprocal multiply
    always_comb
    begin
        coord_ext[0] = {lat_millideg[LAT_W-1], lat_millideg};
        coord_ext[1] = lon_millideg;
        for (int i = 0; i < 2; i++)
        begin
            neg[i]  = coord_ext[i][MAG_W-1];
            mag[i]  = neg[i] ? (~coord_ext[i] + 1'b1) : coord_ext[i];
            prod[i] = PROD_W'(mag[i]) * PROD_W'(RECIP1);
        end
    end

    // stage B: tenths, exact-boundary fix for negatives, second multiply
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            t_raw[i] = a_prod_reg[i][RECIP1_SHIFT +: T_W];
            rem[i]   = a_mag_reg[i] - MAG_W'(t_raw[i]) * HUNDRED_M;
            t_adj[i] = (a_neg_reg[i] && (rem[i] == '0)) ? (t_raw[i] - 1'b1) : t_raw[i];
            p2[i]    = P2_W'(t_adj[i]) * RECIP2;
        end
    end

    // output side: quarter within the band, quadrant digits, key select
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            q2[i]     = b_p2_reg[i][RECIP2_SHIFT +: Q2_W];
            r_full[i] = b_t_reg[i] - T_W'(q2[i]) * HUNDRED_T;
            if (r_full[i] >= 12'd75)
                quarter[i] = 2'd3;
            else if (r_full[i] >= 12'd50)
                quarter[i] = 2'd2;
            else if (r_full[i] >= 12'd25)
                quarter[i] = 2'd1;
            else
                quarter[i] = 2'd0;
        end
        tens_prod = 15'(b_ms1_reg) * 15'd205;   // /10 for values < 160, which covers the 7-bit input
        tens      = tens_prod[14:11];
        units     = b_ms1_reg - SUB_W'(tens) * 7'd10;
        case (b_size_reg)
            SIZE_5DEG:   key = {5'd0, (tens >= 4'd5), (units >= 7'd5)};
            SIZE_2P5DEG: key = {3'd0, quarter[0], quarter[1]};
            SIZE_1DEG:   key = b_ms1_reg;
            default:     key = '0;
        endcase
        wr_word.major   = b_major_reg;
        wr_word.sub_key = key;
        wr_word.coarse  = (b_size_reg == SIZE_10DEG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= push;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 2; i++)
            begin
                a_prod_reg[i] <= prod[i];
                a_mag_reg[i]  <= mag[i];
                b_t_reg[i]    <= t_adj[i];
                b_p2_reg[i]   <= p2[i];
            end
            a_neg_reg   <= neg;
            a_major_reg <= square_major;
            a_ms1_reg   <= sub_square_one;
            a_size_reg  <= size;
            b_major_reg <= a_major_reg;
            b_ms1_reg   <= a_ms1_reg;
            b_size_reg  <= a_size_reg;
        end
    end

endmodule

`default_nettype wire

// ----- design/msba_queue.sv -----
// msba_queue: four-word queue between classifier and bin engine.
// Depends on msba_pkg for the queue word type.
`default_nettype none

module msba_queue
    import msba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    input  msba_work_t wr_word,
    output logic       wr_full,
    input  logic       rd_pop,
    output logic       rd_empty,
    output msba_work_t rd_word
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    msba_work_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign rd_empty = (count_reg == '0);
    assign do_wr    = wr_valid && !wr_full;
    assign do_rd    = rd_pop && !rd_empty;
    assign rd_word  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

`default_nettype wire

// ----- design/msba_back.sv -----
// msba_back: bin engine - sequential key scan, in-order allocation,
// saturating count update and result register. Depends on msba_pkg.
`default_nettype none

module msba_back
    import msba_pkg::*;
#(
    parameter int BIN_SLOTS = 50
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  msba_work_t         q_word,
    output logic               empty,
    input  logic               pop,
    output logic [BIN_W-1:0]   bin_index,
    output logic               new_bin,
    output logic [SUB_W-1:0]   sub_key,
    output logic [COUNT_W-1:0] station_count
);

    localparam int IDX_W = $clog2(BIN_SLOTS + 1);
    localparam int KA_W  = (BIN_SLOTS > 1) ? $clog2(BIN_SLOTS) : 1;
    localparam int KEY_W = MAJOR_W + SUB_W;

    msba_bstate_t state_reg, state_next;

    logic [IDX_W-1:0]   used_reg, used_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]   target_reg, target_next;
    logic               fresh_reg, fresh_next;
    msba_work_t         work_reg, work_next;
    logic [BIN_SLOTS:0] cvalid_reg;

    logic [KEY_W-1:0]   kmem [BIN_SLOTS];
    logic [KEY_W-1:0]   kmem_rd_reg;
    logic [COUNT_W-1:0] cmem [BIN_SLOTS+1];
    logic [COUNT_W-1:0] cmem_rd_reg;
    logic               kmem_we;
    logic               cmem_we;

    logic               out_valid_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic               out_new_reg;
    logic [SUB_W-1:0]   out_sub_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               hit;
    logic               last_scan;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W-1:0] cnt_new;

    assign hit = (kmem_rd_reg[KEY_W-1:SUB_W] == work_reg.major)
              && (work_reg.coarse || (kmem_rd_reg[SUB_W-1:0] == work_reg.sub_key));
    assign last_scan = ((scan_reg + IDX_W'(1)) == used_reg);
    assign cnt_cur   = cvalid_reg[target_reg] ? cmem_rd_reg : '0;
    assign cnt_new   = (&cnt_cur) ? cnt_cur : (cnt_cur + 1'b1);

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        scan_next   = scan_reg;
        target_next = target_reg;
        fresh_next  = fresh_reg;
        work_next   = work_reg;
        q_pop       = 1'b0;
        kmem_we     = 1'b0;
        cmem_we     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_word;
                    scan_next  = '0;
                    fresh_next = 1'b0;
                    state_next = (used_reg == '0) ? B_MISS : B_RD;
                end
            end
            B_RD:
                state_next = B_CMP;
            B_CMP:
            begin
                if (hit)
                begin
                    target_next = scan_reg;
                    state_next  = B_CNT_RD;
                end
                else if (last_scan)
                    state_next = B_MISS;
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_MISS:
            begin
                if (used_reg < IDX_W'(BIN_SLOTS))
                begin
                    kmem_we     = 1'b1;
                    target_next = used_reg;
                    fresh_next  = 1'b1;
                    used_next   = used_reg + 1'b1;
                end
                else
                    target_next = IDX_W'(BIN_SLOTS);   // overflow bin
                state_next = B_CNT_RD;
            end
            B_CNT_RD:
                state_next = B_CNT_WR;
            B_CNT_WR:
            begin
                if (!out_valid_reg || pop)
                begin
                    cmem_we    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            scan_reg      <= '0;
            fresh_reg     <= 1'b0;
            cvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            scan_reg  <= scan_next;
            fresh_reg <= fresh_next;
            if (cmem_we)
            begin
                cvalid_reg[target_reg] <= 1'b1;
                out_valid_reg          <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        target_reg <= target_next;
        if (cmem_we)
        begin
            out_bin_reg   <= BIN_W'(target_reg);
            out_new_reg   <= fresh_reg;
            out_sub_reg   <= work_reg.sub_key;
            out_count_reg <= cnt_new;
        end
    end

    // key and count memories
    always_ff @(posedge clk)
    begin
        if (kmem_we)
            kmem[used_reg[KA_W-1:0]] <= {work_reg.major, work_reg.sub_key};
        if (state_reg == B_RD)
            kmem_rd_reg <= kmem[scan_reg[KA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmem_we)
            cmem[target_reg] <= cnt_new;
        if (state_reg == B_CNT_RD)
            cmem_rd_reg <= cmem[target_reg];
    end

    assign empty         = !out_valid_reg;
    assign bin_index     = out_bin_reg;
    assign new_bin       = out_new_reg;
    assign sub_key       = out_sub_reg;
    assign station_count = out_count_reg;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= IDX_W'(BIN_SLOTS))
        else $error("bins in use beyond table size");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMP) |-> (scan_reg < used_reg))
        else $error("scan past allocated bins");

    a_fresh_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmem_we && fresh_reg) |-> (target_reg == (used_reg - 1'b1)))
        else $error("fresh bin is not the newest one");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_count_reg)))
        else $error("waiting result changed");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_marsden_square_bin_allocator.sv -----
// tb_marsden_square_bin_allocator: self-checking bench for the Marsden square bin
// allocator. Drives station words, mirrors the bin table and checks every bin word.
// Depends on msba_pkg and marsden_square_bin_allocator.
`default_nettype none

module tb_marsden_square_bin_allocator
    import msba_pkg::*;
();

    localparam int BIN_SLOTS      = 50;
    // Worst case is roughly 950 words, each a full miss scan plus the longest
    // stall on either side; this is several times that.
    localparam int CYCLE_LIMIT    = 1_000_000;
    // Drain allowance: one full miss scan plus the classifier and queue stages.
    localparam int TAIL_CYCLES    = 2 * BIN_SLOTS + 20;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_WORDS    = 70;
    localparam int BURST_WORDS    = 40;

    // one station word as driven on the input side
    typedef struct {
        logic [MAJOR_W-1:0]      major;
        logic [SUB_W-1:0]        sub;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } station_t;

    // one bin word as seen on the output side
    typedef struct {
        logic [BIN_W-1:0]   bin;
        logic               fresh;
        logic [SUB_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } bin_word_t;

    logic                    clk;
    logic                    rst_n          = 1'b0;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              square_size    = SIZE_10DEG;
    logic                    push           = 1'b0;
    logic                    full;
    logic [MAJOR_W-1:0]      square_major   = '0;
    logic [SUB_W-1:0]        sub_square_one = '0;
    logic signed [LAT_W-1:0] lat_millideg   = '0;
    logic signed [LON_W-1:0] lon_millideg   = '0;
    logic                    empty;
    logic                    pop            = 1'b0;
    logic [BIN_W-1:0]        bin_index;
    logic                    new_bin;
    logic [SUB_W-1:0]        sub_key;
    logic [COUNT_W-1:0]      station_count;

    marsden_square_bin_allocator #(
        .BIN_SLOTS (BIN_SLOTS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .square_size    (square_size),
        .push           (push),
        .full           (full),
        .square_major   (square_major),
        .sub_square_one (sub_square_one),
        .lat_millideg   (lat_millideg),
        .lon_millideg   (lon_millideg),
        .empty          (empty),
        .pop            (pop),
        .bin_index      (bin_index),
        .new_bin        (new_bin),
        .sub_key        (sub_key),
        .station_count  (station_count)
    );

    // ------------------------------------------------------------------
    // Mirror of the bin table. Only entries below bins_taken are ever
    // read, same as in the block, so the key stores need no reset.
    // ------------------------------------------------------------------
    logic [1:0]         size_now = SIZE_10DEG;
    logic [MAJOR_W-1:0] major_tab [BIN_SLOTS];
    logic [SUB_W-1:0]   subkey_tab [BIN_SLOTS];
    bit [COUNT_W-1:0]   count_tab [BIN_SLOTS + 1];   // last entry is overflow
    int                 bins_taken = 0;

    bin_word_t          bin_words [$];   // bin words still owed by the block
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 push_idle = 1'b0;
    bit                 pop_idle = 1'b0;
    int                 pop_hold = 0;

    logic [MAJOR_W-1:0] major_pool [6] = '{14'd0, 14'd9999, 14'd1234, 14'd42,
                                           14'd8191, 14'd500};
    logic [SUB_W-1:0]   sub_pool [8]   = '{7'd0, 7'd4, 7'd5, 7'd49, 7'd50, 7'd99,
                                           7'd127, 7'd73};

    // Quarter of a coordinate within its 10-degree band, from tenths of a
    // degree. A negative exact multiple of 0.1 deg drops one tenth.
    function automatic int tenth_quarter(input longint milli);
        longint t;
        longint mag;
        if (milli >= 0)
        begin
            t = milli / 100;
        end
        else
        begin
            mag = -milli;
            t   = mag / 100;
            if (mag % 100 == 0)
                t = t - 1;
        end
        return int'((t % 100) / 25);
    endfunction

    function automatic logic [SUB_W-1:0] derive_sub_key(input station_t s,
                                                        input logic [1:0] size);
        int ms;
        int k;
        ms = int'(s.sub);
        case (size)
            SIZE_5DEG:   k = ((ms / 10) >= 5 ? 2 : 0) + ((ms % 10) >= 5 ? 1 : 0);
            SIZE_2P5DEG: k = tenth_quarter(longint'(s.lat)) * 4
                             + tenth_quarter(longint'(s.lon));
            SIZE_1DEG:   k = ms;
            default:     k = 0;
        endcase
        return SUB_W'(k);
    endfunction

    // Look up (major, sub-key), allocate on a miss, bump the saturating count.
    function automatic bin_word_t allocate_bin(input station_t s);
        bin_word_t w;
        int        j;
        int        i;
        bit        hit;
        w.key   = derive_sub_key(s, size_now);
        w.fresh = 1'b0;
        hit     = 1'b0;
        j       = 0;
        for (i = 0; i < bins_taken && !hit; i++)
        begin
            if (major_tab[i] == s.major &&
                (size_now == SIZE_10DEG || subkey_tab[i] == w.key))
            begin
                hit = 1'b1;
                j   = i;
            end
        end
        if (!hit)
        begin
            if (bins_taken < BIN_SLOTS)
            begin
                j             = bins_taken;
                major_tab[j]  = s.major;
                subkey_tab[j] = w.key;
                bins_taken++;
                w.fresh       = 1'b1;
            end
            else
            begin
                j = BIN_SLOTS;   // table full: overflow bin
            end
        end
        if (count_tab[j] != '1)
            count_tab[j]++;
        w.bin   = BIN_W'(j);
        w.count = count_tab[j];
        return w;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pooled words revisit a handful of squares so hits are common; wild
    // words toggle every input bit, out-of-range values included.
    function automatic station_t random_station();
        station_t s;
        int       la;
        int       lo;
        if ($urandom_range(0, 99) < 15)
        begin
            s.major = MAJOR_W'($urandom);
            s.sub   = SUB_W'($urandom);
            s.lat   = LAT_W'($urandom);
            s.lon   = LON_W'($urandom);
        end
        else
        begin
            s.major = major_pool[$urandom_range(0, 5)];
            s.sub   = sub_pool[$urandom_range(0, 7)];
            la      = int'($urandom_range(0, 180000)) - 90000;
            lo      = int'($urandom_range(0, 360000)) - 180000;
            if ($urandom_range(0, 3) == 0)
            begin
                // land on exact tenths, negative boundaries included
                la = (la / 100) * 100;
                lo = (lo / 100) * 100;
            end
            s.lat = LAT_W'(la);
            s.lon = LON_W'(lo);
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: pop with random stalls, check each word taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (pop && !empty)
        begin
            // word taken at this edge; maybe stall before the next one
            if (pick_gap(pop_idle) > 0)
            begin
                pop      <= 1'b0;
                pop_hold <= pick_gap(pop_idle);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_bin_words
        bin_word_t w;
        if (rst_n && pop && !empty)
        begin
            if (bin_words.size() == 0)
            begin
                $error("bin word with none expected: bin_index %0d", bin_index);
                fail_count++;
            end
            else
            begin
                w = bin_words.pop_front();
                if (bin_index !== w.bin)
                begin
                    $error("bin_index: expected %0d, got %0d", w.bin, bin_index);
                    fail_count++;
                end
                if (new_bin !== w.fresh)
                begin
                    $error("new_bin: expected %0d, got %0d", w.fresh, new_bin);
                    fail_count++;
                end
                if (sub_key !== w.key)
                begin
                    $error("sub_key: expected %0d, got %0d", w.key, sub_key);
                    fail_count++;
                end
                if (station_count !== w.count)
                begin
                    $error("station_count: expected %0d, got %0d", w.count,
                           station_count);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Holds push until the word is taken, records its bin word, then maybe
    // idles. With no gap push stays high and the next call swaps the data.
    task automatic send_station(input station_t s);
        int gap;
        push           <= 1'b1;
        square_major   <= s.major;
        sub_square_one <= s.sub;
        lat_millideg   <= s.lat;
        lon_millideg   <= s.lon;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bin_words.push_back(allocate_bin(s));
        gap = pick_gap(push_idle);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_point(input int major, input int sub, input int lat,
                              input int lon);
        station_t s;
        s.major = MAJOR_W'(major);
        s.sub   = SUB_W'(sub);
        s.lat   = LAT_W'(lat);
        s.lon   = LON_W'(lon);
        send_station(s);
    endtask

    task automatic send_random(input int n);
        push_idle = ($urandom_range(0, 3) != 0);
        pop_idle  = ($urandom_range(0, 3) != 0);
        repeat (n) send_station(random_station());
    endtask

    task automatic wait_drained();
        while (bin_words.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only with the block idle: drained plus a scan's worth.
    task automatic set_size(input logic [1:0] size);
        push <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        cfg_valid   <= 1'b1;
        square_size <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_now   = size;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // 10 deg: major only; extremes and a repeat that must hit.
    task automatic test_coarse_major();
        set_size(SIZE_10DEG);
        send_point(0, 0, 0, 0);
        send_point(9999, 99, 90000, 180000);
        send_point(16383, 127, -131072, -262144);
        send_point(0, 55, -90000, -180000);   // same major, other sub: hit
        send_random(BURST_WORDS);
    endtask

    // 5 deg: quadrant digits on both sides of 5, subsquare above 99.
    task automatic test_quadrant_keys();
        set_size(SIZE_5DEG);
        send_point(100, 4, 0, 0);
        send_point(100, 5, 0, 0);
        send_point(100, 50, 0, 0);
        send_point(100, 55, 0, 0);
        send_point(100, 99, 0, 0);
        send_point(100, 127, 0, 0);
        send_random(BURST_WORDS);
    endtask

    // 2.5 deg: zero, negative exact tenths, quarter edges, out-of-range coords.
    task automatic test_tenth_quarters();
        set_size(SIZE_2P5DEG);
        send_point(200, 0, 0, 0);
        send_point(200, 0, -100, -100);
        send_point(200, 0, -2500, -10000);
        send_point(200, 0, 2499, -2501);
        send_point(200, 0, 131071, 262143);
        send_point(200, 0, -90000, -180000);
        send_random(BURST_WORDS);
    endtask

    // 1 deg: subsquare passes straight through.
    task automatic test_one_degree_keys();
        set_size(SIZE_1DEG);
        send_point(300, 0, 0, 0);
        send_point(300, 99, 0, 0);
        send_point(300, 127, 0, 0);
        send_random(BURST_WORDS);
    endtask

    // Size changes between phases over bins made under other sizes.
    task automatic test_size_changes();
        logic [1:0] order [4] = '{SIZE_1DEG, SIZE_10DEG, SIZE_2P5DEG, SIZE_5DEG};
        int         p;
        for (p = 0; p < RAND_PHASES; p++)
        begin
            if (p < 4)
                set_size(order[p]);
            else
                set_size(2'($urandom_range(0, 3)));
            send_random(PHASE_WORDS);
        end
    endtask

    // Fill whatever is left of the table, then overflow and hits on a full table.
    task automatic test_table_full();
        int n;
        set_size(SIZE_10DEG);
        push_idle = 1'b0;
        pop_idle  = 1'b1;
        n = 10000;
        while (bins_taken < BIN_SLOTS)
        begin
            send_point(n, 0, 0, 0);
            n++;
        end
        push_idle = 1'b1;
        repeat (15) send_point(n + $urandom_range(0, 3), 0, 0, 0);
        repeat (10) send_point(int'(major_tab[$urandom_range(0, BIN_SLOTS - 1)]),
                               0, 0, 0);
        set_size(SIZE_1DEG);
        send_random(20);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coarse_major();
        test_quadrant_keys();
        test_tenth_quarters();
        test_one_degree_keys();
        test_size_changes();
        test_table_full();

        push <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
